// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Types and constants of the coefficient rejection sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crs_pkg;

    localparam int POLY_LENGTH_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_BOUND    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA1_BOUND = 2'd3;

    // Sampling modes
    localparam logic [1:0] MODE_UNIFORM = 2'd0;
    localparam logic [1:0] MODE_ETA     = 2'd1;
    localparam logic [1:0] MODE_GAMMA1  = 2'd2;

    // Register reset values
    localparam logic [1:0]  MODE_RST    = MODE_UNIFORM;
    localparam logic [22:0] MODULUS_RST = 23'd8380417;
    localparam logic [2:0]  ETA_RST     = 3'd2;
    localparam logic [19:0] GAMMA1_RST  = 20'd523776;

    // Group sizes in bytes, and the smallest eta bound that uses 4-bit fields
    localparam logic [2:0] UNIFORM_BYTES = 3'd3;
    localparam logic [2:0] GAMMA1_BYTES  = 3'd5;
    localparam logic [2:0] ETA_WIDE_MIN  = 3'd4;

    typedef struct packed {
        logic [7:0] rand_byte;
        logic       start_poly;
    } in_word_t;

    typedef struct packed {
        logic [23:0] coefficient;
        logic [7:0]  coeff_index;
        logic        run_last;
        logic        poly_done;
    } out_word_t;

    // One queued byte outcome: one or two accepted coefficients
    typedef struct packed {
        logic [23:0] coef0;
        logic [23:0] coef1;
        logic [7:0]  index;
        logic        done0;
        logic        done1;
        logic        pair;
    } entry_t;

endpackage

// File: rtl/crs_front.sv
// ----------------------------------------------------------------------------
// crs_front
// Accepts bytes, packs groups, tests candidates and queues accepted ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crs_front #(
    parameter int POLY_LENGTH = crs_pkg::POLY_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           byte_valid,
    input  crs_pkg::in_word_t              byte_word,
    output logic                           byte_stall,
    input  logic                           full,
    output logic                           push,
    output crs_pkg::entry_t                entry
);
    import crs_pkg::*;

    localparam int CNT_W = $clog2(POLY_LENGTH + 1);

    logic [1:0]       mode_reg;
    logic [22:0]      modulus_reg;
    logic [2:0]       eta_reg;
    logic [19:0]      gamma_reg;
    logic [39:0]      acc_reg, acc_next;
    logic [2:0]       pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic [7:0]       b;
    logic [39:0]      acc_cur, acc_pack;
    logic [2:0]       pos_cur, pos_pack;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W:0]   cnt_p1, cnt_p2;
    logic             room0;

    logic [22:0]      t_u;
    logic             ok_u;
    logic             eta_small;
    logic [3:0]       eta_lim, te0, te1;
    logic [23:0]      eta_base;
    logic [19:0]      tg0, tg1;
    logic [21:0]      g_lim;
    logic [23:0]      g_base;

    logic             hit0, hit1, hit1_ok;
    logic [23:0]      val0, val1;

    assign accept     = byte_valid && !byte_stall;
    assign byte_stall = full;
    assign b          = byte_word.rand_byte;

    assign acc_cur = byte_word.start_poly ? '0 : acc_reg;
    assign pos_cur = byte_word.start_poly ? '0 : pos_reg;
    assign cnt_cur = byte_word.start_poly ? '0 : cnt_reg;
    assign cnt_p1  = {1'b0, cnt_cur} + (CNT_W+1)'(1);
    assign cnt_p2  = {1'b0, cnt_cur} + (CNT_W+1)'(2);
    assign room0   = cnt_cur < CNT_W'(POLY_LENGTH);

    // bytes beyond bit 39 fall off the top
    assign acc_pack = acc_cur | (40'(b) << {pos_cur, 3'b000});
    assign pos_pack = pos_cur + 3'd1;

    assign t_u  = acc_pack[22:0];
    assign ok_u = t_u < modulus_reg;

    assign eta_small = eta_reg < ETA_WIDE_MIN;
    assign eta_lim   = {eta_reg, 1'b0};
    assign te0       = eta_small ? {1'b0, b[2:0]} : b[3:0];
    assign te1       = eta_small ? {1'b0, b[7:5]} : b[7:4];
    assign eta_base  = 24'(modulus_reg) + 24'(eta_reg);

    assign tg0    = acc_pack[19:0];
    assign tg1    = acc_pack[39:20];
    assign g_lim  = {1'b0, gamma_reg, 1'b0};
    assign g_base = 24'(modulus_reg) + 24'(gamma_reg) - 24'd1;

    always_comb
    begin
        acc_next = acc_cur;
        pos_next = pos_cur;
        hit0     = 1'b0;
        hit1     = 1'b0;
        val0     = '0;
        val1     = '0;
        if (room0)
        begin
            unique case (mode_reg)
                MODE_UNIFORM:
                begin
                    acc_next = acc_pack;
                    pos_next = pos_pack;
                    if (pos_pack >= UNIFORM_BYTES)
                    begin
                        acc_next = '0;
                        pos_next = '0;
                        hit0     = ok_u;
                        val0     = 24'(t_u);
                    end
                end
                MODE_ETA:
                begin
                    hit0 = te0 <= eta_lim;
                    hit1 = te1 <= eta_lim;
                    val0 = eta_base - 24'(te0);
                    val1 = eta_base - 24'(te1);
                end
                MODE_GAMMA1:
                begin
                    acc_next = acc_pack;
                    pos_next = pos_pack;
                    if (pos_pack >= GAMMA1_BYTES)
                    begin
                        acc_next = '0;
                        pos_next = '0;
                        hit0     = (22'(tg0) + 22'd2) <= g_lim;
                        hit1     = (22'(tg1) + 22'd2) <= g_lim;
                        val0     = g_base - 24'(tg0);
                        val1     = g_base - 24'(tg1);
                    end
                end
                default:
                begin
                    // unused mode: drop the byte
                end
            endcase
        end
    end

    // second coefficient only while the polynomial still has room
    assign hit1_ok = hit1 && (!hit0 || (cnt_p1 < (CNT_W+1)'(POLY_LENGTH)));

    always_comb
    begin
        cnt_next = cnt_cur + CNT_W'(hit0) + CNT_W'(hit1_ok);
    end

    assign push        = accept && (hit0 || hit1_ok);
    assign entry.coef0 = hit0 ? val0 : val1;
    assign entry.coef1 = val1;
    assign entry.index = 8'(cnt_cur);
    assign entry.done0 = cnt_p1 == (CNT_W+1)'(POLY_LENGTH);
    assign entry.done1 = cnt_p2 == (CNT_W+1)'(POLY_LENGTH);
    assign entry.pair  = hit0 && hit1_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RST;
            modulus_reg <= MODULUS_RST;
            eta_reg     <= ETA_RST;
            gamma_reg   <= GAMMA1_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_MODE:  mode_reg    <= cfg_data[1:0];
                CFG_MODULUS:      modulus_reg <= cfg_data[22:0];
                CFG_ETA_BOUND:    eta_reg     <= cfg_data[2:0];
                CFG_GAMMA1_BOUND: gamma_reg   <= cfg_data[19:0];
                default:          mode_reg    <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_HOLDS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(POLY_LENGTH),
        "coefficient count passed the polynomial length")

endmodule

// File: rtl/crs_queue.sv
// ----------------------------------------------------------------------------
// crs_queue
// Short FIFO of byte outcomes between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crs_queue #(
    parameter int DEPTH = crs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crs_pkg::entry_t wdata,
    input  logic            pop,
    output crs_pkg::entry_t rdata,
    output logic            full,
    output logic            empty
);
    import crs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into a full queue")
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from an empty queue")

endmodule

// File: rtl/crs_back.sv
// ----------------------------------------------------------------------------
// crs_back
// Drains queued outcomes to the output register, one coefficient a free cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  crs_pkg::entry_t    head,
    input  logic               empty,
    output logic               pop,
    output logic               coef_valid,
    input  logic               coef_stall,
    output crs_pkg::out_word_t coef_word
);
    import crs_pkg::*;

    logic      valid_reg;
    logic      sel_reg, sel_next;
    out_word_t word_reg, word_next;
    logic      load, last;

    assign load = !empty && (!valid_reg || !coef_stall);
    assign last = !head.pair || sel_reg;
    assign pop  = load && last;

    always_comb
    begin
        word_next.coefficient = sel_reg ? head.coef1 : head.coef0;
        word_next.coeff_index = sel_reg ? head.index + 8'd1 : head.index;
        word_next.run_last    = last;
        word_next.poly_done   = sel_reg ? head.done1 : head.done0;
        sel_next              = load ? !last : sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!coef_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign coef_valid = valid_reg;
    assign coef_word  = word_reg;

    // second half of a pair keeps its entry at the queue head
    `ASSERT_HOLDS(a_sel_head, clk, rst_n, sel_reg |-> !empty,
        "second coefficient pending with an empty queue")

endmodule

// File: rtl/coefficient_rejection_sampler.sv
// ----------------------------------------------------------------------------
// coefficient_rejection_sampler
// Byte stream to polynomial coefficients by rejection sampling.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+------------------------------------
//  byte      | in  | byte_valid/stall   | rand_byte, start_poly
//  coef      | out | coef_valid/stall   | coefficient, coeff_index, run_last,
//            |     |                    | poly_done
//  cfg       | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  One byte is accepted per cycle while byte_stall is low; the front tests it in
//  that cycle. The output register sends one coefficient per cycle while
//  coef_stall is low, so a byte that yields two coefficients holds the back for
//  both; the queue (QUEUE_DEPTH entries) absorbs that. A result passes through
//  the queue and then the output register. Reset is immediate, no clearing pass.
//  byte_stall rises only when the queue is full; cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coefficient_rejection_sampler #(
    parameter int POLY_LENGTH = crs_pkg::POLY_LENGTH_DEF,
    parameter int QUEUE_DEPTH = crs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           byte_valid,
    output logic                           byte_stall,
    input  crs_pkg::in_word_t              byte_word,
    output logic                           coef_valid,
    input  logic                           coef_stall,
    output crs_pkg::out_word_t             coef_word
);
    import crs_pkg::*;

    logic   push, pop, full, empty;
    entry_t q_in, q_head;

    assign cfg_ready = 1'b1;

    crs_front #(
        .POLY_LENGTH(POLY_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_word  (byte_word),
        .byte_stall (byte_stall),
        .full       (full),
        .push       (push),
        .entry      (q_in)
    );

    crs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_in),
        .pop   (pop),
        .rdata (q_head),
        .full  (full),
        .empty (empty)
    );

    crs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .empty      (empty),
        .pop        (pop),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef_word  (coef_word)
    );

endmodule

// File: tb/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker
// Watches the config, byte and coefficient channels of the rejection
// sampler, predicts every coefficient word from the accepted bytes and
// compares the coefficient words in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_checker #(
    parameter int POLY_LENGTH = crs_pkg::POLY_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           byte_valid,
    input  logic                           byte_stall,
    input  crs_pkg::in_word_t              byte_word,
    input  logic                           coef_valid,
    input  logic                           coef_stall,
    input  crs_pkg::out_word_t             coef_word,
    output int                             mismatches,
    output int                             outstanding,
    output int                             coefs_checked,
    output int                             polys_completed
);
    import crs_pkg::*;

    // Shadow configuration
    logic [1:0]  mode_r;
    logic [22:0] modulus_r;
    logic [2:0]  eta_r;
    logic [19:0] gamma1_r;

    // Shadow sampling state
    logic [39:0] acc_bytes;
    logic [2:0]  acc_pos;
    int          coef_count;

    out_word_t   expected_coefs[$];
    out_word_t   want;
    int          fail_count;
    int          seen_count;
    int          done_count;

    assign mismatches      = fail_count;
    assign coefs_checked   = seen_count;
    assign polys_completed = done_count;

    task automatic accept_coef(input logic [31:0] value);
        out_word_t w;
        w.coefficient = value[23:0];
        w.coeff_index = coef_count[7:0];
        w.run_last    = 1'b0;
        w.poly_done   = (coef_count + 1 == POLY_LENGTH);
        coef_count    = coef_count + 1;
        expected_coefs.push_back(w);
    endtask

    task automatic pack_byte(input logic [7:0] b);
        // bytes shifted past bit 39 are lost
        acc_bytes = acc_bytes | 40'(64'(b) << (8 * acc_pos));
        acc_pos   = acc_pos + 3'd1;
    endtask

    task automatic sample_byte(input in_word_t w);
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] lim;
        logic [31:0] base;
        int          first;
        out_word_t   tail;
        first = expected_coefs.size();
        if (w.start_poly)
        begin
            acc_bytes  = '0;
            acc_pos    = '0;
            coef_count = 0;
        end
        if (coef_count >= POLY_LENGTH)
            return;
        case (mode_r)
            MODE_UNIFORM:
            begin
                pack_byte(w.rand_byte);
                if (acc_pos >= UNIFORM_BYTES)
                begin
                    t0        = 32'(acc_bytes[22:0]);
                    acc_bytes = '0;
                    acc_pos   = '0;
                    if (t0 < 32'(modulus_r))
                        accept_coef(t0);
                end
            end
            MODE_ETA:
            begin
                lim = 32'(eta_r) * 2;
                if (eta_r < ETA_WIDE_MIN)
                begin
                    t0 = 32'(w.rand_byte[2:0]);
                    t1 = 32'(w.rand_byte[7:5]);
                end
                else
                begin
                    t0 = 32'(w.rand_byte[3:0]);
                    t1 = 32'(w.rand_byte[7:4]);
                end
                if (t0 <= lim)
                    accept_coef(32'(modulus_r) + 32'(eta_r) - t0);
                if (t1 <= lim && coef_count < POLY_LENGTH)
                    accept_coef(32'(modulus_r) + 32'(eta_r) - t1);
            end
            MODE_GAMMA1:
            begin
                pack_byte(w.rand_byte);
                if (acc_pos >= GAMMA1_BYTES)
                begin
                    t0        = 32'(acc_bytes[19:0]);
                    t1        = 32'(acc_bytes[39:20]);
                    lim       = 32'(gamma1_r) * 2;
                    base      = 32'(modulus_r) + 32'(gamma1_r) - 32'd1;
                    acc_bytes = '0;
                    acc_pos   = '0;
                    if (t0 + 32'd2 <= lim)
                        accept_coef(base - t0);
                    if (t1 + 32'd2 <= lim && coef_count < POLY_LENGTH)
                        accept_coef(base - t1);
                end
            end
            default: ;  // spare mode: drop the byte
        endcase
        // flag the last word this byte produced
        if (expected_coefs.size() > first)
        begin
            tail          = expected_coefs.pop_back();
            tail.run_last = 1'b1;
            expected_coefs.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r     <= MODE_RST;
            modulus_r  <= MODULUS_RST;
            eta_r      <= ETA_RST;
            gamma1_r   <= GAMMA1_RST;
            acc_bytes  = '0;
            acc_pos    = '0;
            coef_count = 0;
            expected_coefs.delete();
            fail_count = 0;
            seen_count = 0;
            done_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_MODE:  mode_r    <= cfg_data[1:0];
                    CFG_MODULUS:      modulus_r <= cfg_data[22:0];
                    CFG_ETA_BOUND:    eta_r     <= cfg_data[2:0];
                    CFG_GAMMA1_BOUND: gamma1_r  <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (coef_valid && !coef_stall)
            begin
                if (expected_coefs.size() == 0)
                begin
                    $error("coefficient word with nothing expected: coefficient %0d index %0d",
                           coef_word.coefficient, coef_word.coeff_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    seen_count++;
                    if (want.poly_done)
                        done_count++;
                    if (coef_word.coefficient !== want.coefficient)
                    begin
                        $error("coefficient: expected %0d, got %0d",
                               want.coefficient, coef_word.coefficient);
                        fail_count++;
                    end
                    if (coef_word.coeff_index !== want.coeff_index)
                    begin
                        $error("coeff_index: expected %0d, got %0d",
                               want.coeff_index, coef_word.coeff_index);
                        fail_count++;
                    end
                    if (coef_word.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, coef_word.run_last);
                        fail_count++;
                    end
                    if (coef_word.poly_done !== want.poly_done)
                    begin
                        $error("poly_done: expected %0b, got %0b",
                               want.poly_done, coef_word.poly_done);
                        fail_count++;
                    end
                end
            end
            if (byte_valid && !byte_stall)
                sample_byte(byte_word);
            outstanding <= expected_coefs.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the coefficient rejection sampler: a short directed set of
// bytes per mode, then random phases with random settings, random idling on
// both channels, one long output hold-off and one quiet stretch. The checker
// beside the block predicts and compares every coefficient word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import crs_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_BYTES = 600;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_LIMIT = 2000;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SAMPLE_MODE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    in_word_t              byte_word  = '0;
    logic                  coef_valid;
    logic                  coef_stall = 1'b0;
    out_word_t             coef_word;

    int mismatches;
    int outstanding;
    int coefs_checked;
    int polys_completed;

    int idle_pct  = 7;
    int stall_pct = 7;
    bit hold_req  = 1'b0;
    int bytes_sent;
    int settings_used;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    coefficient_rejection_sampler u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef_word  (coef_word)
    );

    crs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .byte_word       (byte_word),
        .coef_valid      (coef_valid),
        .coef_stall      (coef_stall),
        .coef_word       (coef_word),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .coefs_checked   (coefs_checked),
        .polys_completed (polys_completed)
    );

    // Coefficient receiver: random stalls, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                coef_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                coef_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word  <= '{rand_byte: b, start_poly: s};
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic settle();
        int guard;
        guard = 0;
        byte_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0 && guard < SETTLE_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] m, input logic [22:0] q,
                              input logic [2:0] e, input logic [19:0] g);
        write_reg(CFG_SAMPLE_MODE, CFG_DATA_W'(m));
        write_reg(CFG_MODULUS, CFG_DATA_W'(q));
        write_reg(CFG_ETA_BOUND, CFG_DATA_W'(e));
        write_reg(CFG_GAMMA1_BOUND, CFG_DATA_W'(g));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          len;
        int          random_sent;
        bit          fresh;
        logic [1:0]  m;
        logic [22:0] q;
        logic [2:0]  e;
        logic [19:0] g;

        phase         = 0;
        random_sent   = 0;
        bytes_sent    = 0;
        settings_used = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Uniform at reset settings: all-ones group, zero, q itself, q-1
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h7F, 1'b0);

        // Eta with 3-bit fields: both accepted, both rejected
        settle();
        set_config(MODE_ETA, MODULUS_RST, ETA_RST, GAMMA1_RST);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // Eta with nibbles and a tiny modulus: the offset wraps
        settle();
        set_config(MODE_ETA, 23'd1, 3'd7, GAMMA1_RST);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hFF, 1'b0);

        // Gamma1: two values from one group, then a zero bound rejects all
        settle();
        set_config(MODE_GAMMA1, MODULUS_RST, ETA_RST, GAMMA1_RST);
        send_byte(8'h00, 1'b1);
        repeat (4) send_byte(8'h00, 1'b0);
        settle();
        set_config(MODE_GAMMA1, MODULUS_RST, ETA_RST, 20'd0);
        repeat (5) send_byte(8'h00, 1'b0);

        // Spare mode: the byte is dropped
        settle();
        set_config(MODE_SPARE, MODULUS_RST, ETA_RST, GAMMA1_RST);
        send_byte(8'h5A, 1'b0);

        while (random_sent < RANDOM_BYTES)
        begin
            settle();
            if (phase == 1)
            begin
                // fill a polynomial while the receiver holds off
                m = MODE_ETA;
                set_config(m, MODULUS_RST, 3'd7, GAMMA1_RST);
                idle_pct = 0;
                hold_req = 1'b1;
                len      = 170;
                fresh    = 1'b1;
            end
            else if (phase == 4)
            begin
                // quiet stretch, filling another polynomial
                m = MODE_ETA;
                set_config(m, 23'h7FFFFF, 3'd6, 20'd524288);
                idle_pct  = 0;
                stall_pct = 0;
                len       = 200;
                fresh     = 1'b1;
            end
            else
            begin
                m = 2'($urandom_range(2));
                if ($urandom_range(19) == 0)
                    m = MODE_SPARE;
                case ($urandom_range(5))
                    0, 1, 2: q = MODULUS_RST;
                    3:       q = 23'h7FFFFF;
                    4:       q = 23'd1;
                    default: q = 23'($urandom_range(23'h7FFFFF, 1));
                endcase
                e = 3'($urandom_range(7, 1));
                case ($urandom_range(4))
                    0:       g = GAMMA1_RST;
                    1:       g = 20'd524288;
                    2:       g = 20'd1;
                    3:       g = 20'd131072;
                    default: g = 20'($urandom_range(524288, 1));
                endcase
                set_config(m, q, e, g);
                len   = $urandom_range(80, 20);
                fresh = $urandom_range(1);
            end
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)),
                          (i == 0 && fresh) || $urandom_range(99) == 0);
            if (m != MODE_SPARE)
                random_sent += len;
            idle_pct  = 7;
            stall_pct = 7;
            phase++;
        end

        settle();
        if (outstanding != 0)
            $error("%0d coefficient words never arrived", outstanding);
        $display("Sent %0d bytes under %0d settings; checked %0d coefficient words,",
                 bytes_sent, settings_used, coefs_checked);
        $display("%0d of them closing a polynomial.", polys_completed);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
